// ----- design/salm_pkg.sv -----
// Shared widths, step counts and the unit control struct for the stereo level meter.
// No dependencies; imported by the three arithmetic units and the top level.
`default_nettype none

package salm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SQ_W        = 2 * SAMPLE_W;
   localparam int BLOCK_LOG2  = 9;
   localparam int BLOCK_LEN   = 1 << BLOCK_LOG2;
   localparam int POS_W       = BLOCK_LOG2;
   localparam int SUM_W       = SQ_W + BLOCK_LOG2;
   localparam int RAD_W       = SUM_W - BLOCK_LOG2;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int REM_W       = ROOT_W + 3;
   localparam int AVG_W       = 16;
   localparam int WEIGHT_W    = 17;
   localparam int CNT_W       = 32;
   localparam int OUT_CNT_W   = 32;
   localparam int NUM_CNT     = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = WEIGHT_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd3277;

   // serial step counts of the three arithmetic units
   localparam int SQ_STEPS    = SAMPLE_W;
   localparam int ROOT_STEPS  = ROOT_W;
   localparam int BLEND_STEPS = WEIGHT_W;
   localparam int STEP_CNT_W  = 5;

   // CSR register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 1'b0,
      CSR_WEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
   } salm_ctl_type;

endpackage

`default_nettype wire

// ----- design/salm_square.sv -----
// Bit-serial squarer: one multiplier bit per cycle while ctl.step is high, shift-add into a split accumulator.
// Depends on salm_pkg.
`default_nettype none

module salm_square (
   input  logic                         clock,
   input  salm_pkg::salm_ctl_type       ctl,
   input  logic [salm_pkg::SAMPLE_W-1:0] operand,
   output logic [salm_pkg::SQ_W-1:0]     product
);
   import salm_pkg::*;

   logic [SAMPLE_W-1:0] mcand_ff,  mcand_in;
   logic [SAMPLE_W-1:0] mplier_ff, mplier_in;
   logic [SAMPLE_W-1:0] hi_ff,     hi_in;
   logic [SAMPLE_W-1:0] lo_ff,     lo_in;
   logic [SAMPLE_W:0]   partial;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      partial   = {1'b0, hi_ff} + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      if (ctl.load) begin
         mcand_in  = operand;
         mplier_in = operand;
         hi_in     = '0;
         lo_in     = '0;
      end else if (ctl.step) begin
         hi_in     = partial[SAMPLE_W:1];
         lo_in     = {partial[0], lo_ff[SAMPLE_W-1:1]};
         mplier_in = mplier_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
   end

   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ----- design/salm_isqrt.sv -----
// Digit-serial floor square root: two radicand bits in, one root bit out per cycle while ctl.step is high.
// Depends on salm_pkg.
`default_nettype none

module salm_isqrt (
   input  logic                        clock,
   input  salm_pkg::salm_ctl_type      ctl,
   input  logic [salm_pkg::RAD_W-1:0]  radicand,
   output logic [salm_pkg::ROOT_W-1:0] root
);
   import salm_pkg::*;

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (ctl.load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

`default_nettype wire

// ----- design/salm_blend.sv -----
// Serial exponential-average blend: old*(1-w) + rms*w in Q16, one weight bit per cycle while ctl.step is high.
// Depends on salm_pkg.
`default_nettype none

module salm_blend (
   input  logic                          clock,
   input  salm_pkg::salm_ctl_type        ctl,
   input  logic [salm_pkg::AVG_W-1:0]    old_avg,
   input  logic [salm_pkg::ROOT_W-1:0]   blk_rms,
   input  logic [salm_pkg::WEIGHT_W-1:0] weight,
   output logic [salm_pkg::AVG_W-1:0]    new_avg
);
   import salm_pkg::*;

   logic [AVG_W-1:0]        old_ff, old_in;
   logic [ROOT_W-1:0]       rms_ff, rms_in;
   logic [WEIGHT_W-1:0]     w_ff,   w_in;
   logic [WEIGHT_W-1:0]     iw_ff,  iw_in;
   logic [WEIGHT_W-1:0]     hi_ff,  hi_in;
   logic [WEIGHT_W-1:0]     lo_ff,  lo_in;
   logic [WEIGHT_W-1:0]     w_clamp;
   logic [WEIGHT_W-1:0]     addend;
   logic [WEIGHT_W:0]       partial;
   logic [2*WEIGHT_W-1:0]   prod;

   always_comb begin
      old_in  = old_ff;
      rms_in  = rms_ff;
      w_in    = w_ff;
      iw_in   = iw_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      w_clamp = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      addend  = (w_ff[0]  ? WEIGHT_W'(rms_ff) : '0)
              + (iw_ff[0] ? WEIGHT_W'(old_ff) : '0);
      partial = {1'b0, hi_ff} + {1'b0, addend};
      if (ctl.load) begin
         old_in = old_avg;
         rms_in = blk_rms;
         w_in   = w_clamp;
         iw_in  = WEIGHT_ONE - w_clamp;
         hi_in  = '0;
         lo_in  = '0;
      end else if (ctl.step) begin
         hi_in = partial[WEIGHT_W:1];
         lo_in = {partial[0], lo_ff[WEIGHT_W-1:1]};
         w_in  = w_ff >> 1;
         iw_in = iw_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= old_in;
      rms_ff <= rms_in;
      w_ff   <= w_in;
      iw_ff  <= iw_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   // Q16 product, drop the fraction
   assign prod    = {hi_ff, lo_ff};
   assign new_avg = prod[AVG_W+15:16];

endmodule

`default_nettype wire

// ----- design/stereo_audio_level_meter_unit.sv -----
// Stereo level meter top level: sequencer, statistics registers, CSRs, result register.
// Depends on salm_pkg, salm_square, salm_isqrt, salm_blend.
//
// Usage:
//  - req_*: one signed stereo pair per transfer (req_valid high, req_stall low).
//  - rsp_*: one result per request: peaks, saturating counters, averaged RMS and a
//    flag for the pair that closed a block of BLOCK_LEN pairs.
//  - csr_*: register writes (index 0 meter_enable, 1 ema_weight); csr_ready is
//    always high. Write only while no request is in flight.
// Sequence:
//  - A request runs through the bit-serial squarer (ST_SQUARE) and an accumulate
//    state (ST_ACCUM), then ST_EMIT loads the result register and the unit
//    returns to idle, where the next request is taken.
//  - A block-closing pair also passes the digit-serial root (ST_ROOT), the blend
//    load (ST_PREP), the serial blend (ST_BLEND) and ST_WRAP before ST_EMIT.
//  - A pair arriving while meter_enable is 0 skips the arithmetic and goes to ST_EMIT.
//  - req_stall is high while an item is being worked on.
// Reset (synchronous, active high) clears all statistics, restores CSR defaults
// and empties the result register. A stalled result holds; the finished next
// item waits in the emit state until the result register frees up.
`default_nettype none

module stereo_audio_level_meter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [salm_pkg::SAMPLE_W-1:0]  req_left_sample,
   input  logic signed [salm_pkg::SAMPLE_W-1:0]  req_right_sample,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [salm_pkg::SAMPLE_W-1:0]  rsp_peak_left,
   output logic signed [salm_pkg::SAMPLE_W-1:0]  rsp_peak_right,
   output logic [salm_pkg::OUT_CNT_W-1:0]        rsp_clip_count_left,
   output logic [salm_pkg::OUT_CNT_W-1:0]        rsp_clip_count_right,
   output logic [salm_pkg::OUT_CNT_W-1:0]        rsp_zero_cross_left,
   output logic [salm_pkg::OUT_CNT_W-1:0]        rsp_zero_cross_right,
   output logic [salm_pkg::OUT_CNT_W-1:0]        rsp_silent_count,
   output logic [salm_pkg::AVG_W-1:0]            rsp_rms_left,
   output logic [salm_pkg::AVG_W-1:0]            rsp_rms_right,
   output logic [salm_pkg::OUT_CNT_W-1:0]        rsp_pair_count,
   output logic                                 rsp_rms_updated,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [salm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [salm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import salm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SQUARE = 8'b0000_0010,
      ST_ACCUM  = 8'b0000_0100,
      ST_ROOT   = 8'b0000_1000,
      ST_PREP   = 8'b0001_0000,
      ST_BLEND  = 8'b0010_0000,
      ST_WRAP   = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   // event counter slots
   localparam int CNT_CLIP_L = 0;
   localparam int CNT_CLIP_R = 1;
   localparam int CNT_ZC_L   = 2;
   localparam int CNT_ZC_R   = 3;
   localparam int CNT_SILENT = 4;
   localparam int CNT_PAIRS  = 5;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

   function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] v);
      return v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

   // control
   state_type                 state_ff, state_in;
   logic [STEP_CNT_W-1:0]     step_ff,  step_in;
   logic                      accept;
   logic                      rsp_load;
   salm_ctl_type              sq_ctl, rt_ctl, bl_ctl;

   // configuration
   logic                      enable_ff;
   logic [WEIGHT_W-1:0]       weight_ff;

   // statistics
   logic signed [SAMPLE_W-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SAMPLE_W-1:0] peak_l_ff, peak_l_in, peak_r_ff, peak_r_in;
   logic [CNT_W-1:0]          cnt_ff [NUM_CNT];
   logic [CNT_W-1:0]          cnt_in [NUM_CNT];
   logic [SUM_W-1:0]          sum_l_ff, sum_l_in, sum_r_ff, sum_r_in;
   logic [SUM_W-1:0]          sum_l_nx, sum_r_nx;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [AVG_W-1:0]          avg_l_ff, avg_l_in, avg_r_ff, avg_r_in;
   logic                      upd_ff, upd_in;

   // datapath between units
   logic [SQ_W-1:0]           sq_l, sq_r;
   logic [RAD_W-1:0]          rad_l, rad_r;
   logic [ROOT_W-1:0]         root_l, root_r;
   logic [AVG_W-1:0]          blend_l, blend_r;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_peak_l_ff, rsp_peak_r_ff;
   logic [OUT_CNT_W-1:0]      rsp_clip_l_ff, rsp_clip_r_ff, rsp_zc_l_ff, rsp_zc_r_ff;
   logic [OUT_CNT_W-1:0]      rsp_silent_ff, rsp_pairs_ff;
   logic [AVG_W-1:0]          rsp_rms_l_ff, rsp_rms_r_ff;
   logic                      rsp_upd_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_WEIGHT: weight_ff <= csr_wdata;
            default:    enable_ff <= enable_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and statistics update
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      peak_l_in = peak_l_ff;
      peak_r_in = peak_r_ff;
      cnt_in    = cnt_ff;
      sum_l_in  = sum_l_ff;
      sum_r_in  = sum_r_ff;
      pos_in    = pos_ff;
      avg_l_in  = avg_l_ff;
      avg_r_in  = avg_r_ff;
      upd_in    = upd_ff;
      sq_ctl    = '0;
      rt_ctl    = '0;
      bl_ctl    = '0;
      rsp_load  = 1'b0;
      sum_l_nx  = sum_l_ff + SUM_W'(sq_l);
      sum_r_nx  = sum_r_ff + SUM_W'(sq_r);
      // block mean is a plain shift of the updated sum
      rad_l     = sum_l_nx[SUM_W-1:BLOCK_LOG2];
      rad_r     = sum_r_nx[SUM_W-1:BLOCK_LOG2];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               upd_in = 1'b0;
               if (enable_ff) begin
                  // peak: strictly greater magnitude, ties keep the older one
                  if (mag16(req_left_sample) > mag16(peak_l_ff))
                     peak_l_in = req_left_sample;
                  if (mag16(req_right_sample) > mag16(peak_r_ff))
                     peak_r_in = req_right_sample;
                  if (req_left_sample == FULL_POS || req_left_sample == FULL_NEG)
                     cnt_in[CNT_CLIP_L] = sat_inc(cnt_ff[CNT_CLIP_L]);
                  if (req_right_sample == FULL_POS || req_right_sample == FULL_NEG)
                     cnt_in[CNT_CLIP_R] = sat_inc(cnt_ff[CNT_CLIP_R]);
                  if (prev_l_ff[SAMPLE_W-1] != req_left_sample[SAMPLE_W-1])
                     cnt_in[CNT_ZC_L] = sat_inc(cnt_ff[CNT_ZC_L]);
                  if (prev_r_ff[SAMPLE_W-1] != req_right_sample[SAMPLE_W-1])
                     cnt_in[CNT_ZC_R] = sat_inc(cnt_ff[CNT_ZC_R]);
                  if (req_left_sample == '0 && req_right_sample == '0)
                     cnt_in[CNT_SILENT] = sat_inc(cnt_ff[CNT_SILENT]);
                  cnt_in[CNT_PAIRS] = sat_inc(cnt_ff[CNT_PAIRS]);
                  prev_l_in = req_left_sample;
                  prev_r_in = req_right_sample;
                  sq_ctl.load = 1'b1;
                  step_in     = '0;
                  state_in    = ST_SQUARE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SQUARE: begin
            sq_ctl.step = 1'b1;
            if (step_ff == STEP_CNT_W'(SQ_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_ACCUM;
            end else begin
               step_in = step_ff + STEP_CNT_W'(1);
            end
         end
         ST_ACCUM: begin
            if (pos_ff == POS_W'(BLOCK_LEN - 1)) begin
               rt_ctl.load = 1'b1;
               sum_l_in    = '0;
               sum_r_in    = '0;
               pos_in      = '0;
               step_in     = '0;
               state_in    = ST_ROOT;
            end else begin
               sum_l_in = sum_l_nx;
               sum_r_in = sum_r_nx;
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_EMIT;
            end
         end
         ST_ROOT: begin
            rt_ctl.step = 1'b1;
            if (step_ff == STEP_CNT_W'(ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_PREP;
            end else begin
               step_in = step_ff + STEP_CNT_W'(1);
            end
         end
         ST_PREP: begin
            bl_ctl.load = 1'b1;
            step_in     = '0;
            state_in    = ST_BLEND;
         end
         ST_BLEND: begin
            bl_ctl.step = 1'b1;
            if (step_ff == STEP_CNT_W'(BLEND_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_WRAP;
            end else begin
               step_in = step_ff + STEP_CNT_W'(1);
            end
         end
         ST_WRAP: begin
            avg_l_in = blend_l;
            avg_r_in = blend_r;
            upd_in   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold here while the previous result is still stalled
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         peak_l_ff <= '0;
         peak_r_ff <= '0;
         for (int i = 0; i < NUM_CNT; i++) cnt_ff[i] <= '0;
         sum_l_ff  <= '0;
         sum_r_ff  <= '0;
         pos_ff    <= '0;
         avg_l_ff  <= '0;
         avg_r_ff  <= '0;
         upd_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         peak_l_ff <= peak_l_in;
         peak_r_ff <= peak_r_in;
         cnt_ff    <= cnt_in;
         sum_l_ff  <= sum_l_in;
         sum_r_ff  <= sum_r_in;
         pos_ff    <= pos_in;
         avg_l_ff  <= avg_l_in;
         avg_r_ff  <= avg_r_in;
         upd_ff    <= upd_in;
      end
   end

   // ---------------------------------------------------------------------
   // Serial arithmetic lanes
   // ---------------------------------------------------------------------
   salm_square u_square_l (
      .clock   (clock),
      .ctl     (sq_ctl),
      .operand (mag16(req_left_sample)),
      .product (sq_l)
   );

   salm_square u_square_r (
      .clock   (clock),
      .ctl     (sq_ctl),
      .operand (mag16(req_right_sample)),
      .product (sq_r)
   );

   salm_isqrt u_isqrt_l (
      .clock    (clock),
      .ctl      (rt_ctl),
      .radicand (rad_l),
      .root     (root_l)
   );

   salm_isqrt u_isqrt_r (
      .clock    (clock),
      .ctl      (rt_ctl),
      .radicand (rad_r),
      .root     (root_r)
   );

   salm_blend u_blend_l (
      .clock   (clock),
      .ctl     (bl_ctl),
      .old_avg (avg_l_ff),
      .blk_rms (root_l),
      .weight  (weight_ff),
      .new_avg (blend_l)
   );

   salm_blend u_blend_r (
      .clock   (clock),
      .ctl     (bl_ctl),
      .old_avg (avg_r_ff),
      .blk_rms (root_r),
      .weight  (weight_ff),
      .new_avg (blend_r)
   );

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_peak_l_ff <= peak_l_ff;
         rsp_peak_r_ff <= peak_r_ff;
         rsp_clip_l_ff <= cnt_ff[CNT_CLIP_L][OUT_CNT_W-1:0];
         rsp_clip_r_ff <= cnt_ff[CNT_CLIP_R][OUT_CNT_W-1:0];
         rsp_zc_l_ff   <= cnt_ff[CNT_ZC_L][OUT_CNT_W-1:0];
         rsp_zc_r_ff   <= cnt_ff[CNT_ZC_R][OUT_CNT_W-1:0];
         rsp_silent_ff <= cnt_ff[CNT_SILENT][OUT_CNT_W-1:0];
         rsp_pairs_ff  <= cnt_ff[CNT_PAIRS][OUT_CNT_W-1:0];
         rsp_rms_l_ff  <= avg_l_ff;
         rsp_rms_r_ff  <= avg_r_ff;
         rsp_upd_ff    <= upd_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_peak_left        = rsp_peak_l_ff;
   assign rsp_peak_right       = rsp_peak_r_ff;
   assign rsp_clip_count_left  = rsp_clip_l_ff;
   assign rsp_clip_count_right = rsp_clip_r_ff;
   assign rsp_zero_cross_left  = rsp_zc_l_ff;
   assign rsp_zero_cross_right = rsp_zc_r_ff;
   assign rsp_silent_count     = rsp_silent_ff;
   assign rsp_rms_left         = rsp_rms_l_ff;
   assign rsp_rms_right        = rsp_rms_r_ff;
   assign rsp_pair_count       = rsp_pairs_ff;
   assign rsp_rms_updated      = rsp_upd_ff;

endmodule

`default_nettype wire

// ----- design/salm_checker.sv -----
// Port-level checks for the stereo level meter, bound to the top level.
// Depends on stereo_audio_level_meter_unit.
`default_nettype none

module salm_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic rsp_valid,
   input  logic rsp_stall
);

   // result register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item at a time: after a request transfer the input is stalled
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // a new result only appears at the end of an item's work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in flight");

endmodule

bind stereo_audio_level_meter_unit salm_checker u_salm_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for stereo_audio_level_meter_unit: directed and random stereo pairs,
// an in-bench level predictor, random idling on both channels, CSR phases between drains.
// Depends on salm_pkg and the RTL of the unit only.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import salm_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

   localparam int RANDOM_PAIRS = 1250;
   localparam int MAX_REPORTS  = 100;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } sample_pair_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  peak_left;
      logic [SAMPLE_W-1:0]  peak_right;
      logic [OUT_CNT_W-1:0] clip_left;
      logic [OUT_CNT_W-1:0] clip_right;
      logic [OUT_CNT_W-1:0] zc_left;
      logic [OUT_CNT_W-1:0] zc_right;
      logic [OUT_CNT_W-1:0] silent;
      logic [AVG_W-1:0]     rms_left;
      logic [AVG_W-1:0]     rms_right;
      logic [OUT_CNT_W-1:0] pairs;
      logic                 updated;
   } level_result_type;

   // ---------------------------------------------------------------------------------------
   // Clock, reset and DUT pins. Every input starts at a known value.
   // ---------------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_left_sample  = '0;
   logic [SAMPLE_W-1:0]   req_right_sample = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_peak_left;
   logic [SAMPLE_W-1:0]   rsp_peak_right;
   logic [OUT_CNT_W-1:0]  rsp_clip_count_left;
   logic [OUT_CNT_W-1:0]  rsp_clip_count_right;
   logic [OUT_CNT_W-1:0]  rsp_zero_cross_left;
   logic [OUT_CNT_W-1:0]  rsp_zero_cross_right;
   logic [OUT_CNT_W-1:0]  rsp_silent_count;
   logic [AVG_W-1:0]      rsp_rms_left;
   logic [AVG_W-1:0]      rsp_rms_right;
   logic [OUT_CNT_W-1:0]  rsp_pair_count;
   logic                  rsp_rms_updated;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stereo_audio_level_meter_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_left_sample      (req_left_sample),
      .req_right_sample     (req_right_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_peak_left        (rsp_peak_left),
      .rsp_peak_right       (rsp_peak_right),
      .rsp_clip_count_left  (rsp_clip_count_left),
      .rsp_clip_count_right (rsp_clip_count_right),
      .rsp_zero_cross_left  (rsp_zero_cross_left),
      .rsp_zero_cross_right (rsp_zero_cross_right),
      .rsp_silent_count     (rsp_silent_count),
      .rsp_rms_left         (rsp_rms_left),
      .rsp_rms_right        (rsp_rms_right),
      .rsp_pair_count       (rsp_pair_count),
      .rsp_rms_updated      (rsp_rms_updated),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Level predictor: own copy of the CSRs and statistics. Index 0 is left, 1 is right.
   // ---------------------------------------------------------------------------------------
   logic                       cfg_enable;
   logic [WEIGHT_W-1:0]        cfg_weight;
   logic signed [SAMPLE_W-1:0] prev_smp [2];
   logic signed [SAMPLE_W-1:0] peak_smp [2];
   logic [CNT_W-1:0]           clip_cnt [2];
   logic [CNT_W-1:0]           zc_cnt   [2];
   logic [CNT_W-1:0]           silent_cnt;
   logic [CNT_W-1:0]           pairs_cnt;
   logic [SUM_W-1:0]           sum_sq   [2];
   logic [AVG_W-1:0]           rms_avg  [2];
   int                         blk_pos;

   sample_pair_type  pending_q[$];   // pairs waiting for the driver
   level_result_type expected_q[$];  // predicted results, oldest first

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

   function automatic int magnitude(logic signed [SAMPLE_W-1:0] s);
      int v;
      v = int'(s);
      return (v < 0) ? -v : v;
   endfunction

   // floor of the square root, one result bit at a time from the top
   function automatic logic [AVG_W-1:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = AVG_W; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root[AVG_W-1:0];
   endfunction

   // Q16 blend of the running average with a new block RMS; weights above one clamp
   function automatic logic [AVG_W-1:0] blend(logic [AVG_W-1:0] old, logic [AVG_W-1:0] rms);
      logic [63:0] w;
      logic [63:0] acc;
      w   = (cfg_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(cfg_weight);
      acc = 64'(old) * (64'h10000 - w) + 64'(rms) * w;
      return acc[AVG_W+15:16];
   endfunction

   function automatic void update_channel(int ch, logic signed [SAMPLE_W-1:0] s);
      int v;
      v = int'(s);
      if (magnitude(s) > magnitude(peak_smp[ch]))   // tie keeps the earlier peak
         peak_smp[ch] = s;
      if (s == FULL_POS || s == FULL_NEG)
         clip_cnt[ch] = sat_inc(clip_cnt[ch]);
      if (prev_smp[ch][SAMPLE_W-1] != s[SAMPLE_W-1])
         zc_cnt[ch] = sat_inc(zc_cnt[ch]);
      prev_smp[ch] = s;
      sum_sq[ch] = sum_sq[ch] + SUM_W'(v * v);
   endfunction

   function automatic level_result_type predict_levels(logic [SAMPLE_W-1:0] l,
                                                       logic [SAMPLE_W-1:0] r);
      level_result_type res;
      res.updated = 1'b0;
      if (cfg_enable) begin
         update_channel(0, l);
         update_channel(1, r);
         if (l == '0 && r == '0)
            silent_cnt = sat_inc(silent_cnt);
         pairs_cnt = sat_inc(pairs_cnt);
         blk_pos++;
         if (blk_pos >= BLOCK_LEN) begin
            for (int ch = 0; ch < 2; ch++) begin
               rms_avg[ch] = blend(rms_avg[ch], floor_sqrt(64'(sum_sq[ch] >> BLOCK_LOG2)));
               sum_sq[ch]  = '0;
            end
            blk_pos     = 0;
            res.updated = 1'b1;
         end
      end
      res.peak_left  = peak_smp[0];
      res.peak_right = peak_smp[1];
      res.clip_left  = clip_cnt[0][OUT_CNT_W-1:0];
      res.clip_right = clip_cnt[1][OUT_CNT_W-1:0];
      res.zc_left    = zc_cnt[0][OUT_CNT_W-1:0];
      res.zc_right   = zc_cnt[1][OUT_CNT_W-1:0];
      res.silent     = silent_cnt[OUT_CNT_W-1:0];
      res.rms_left   = rms_avg[0];
      res.rms_right  = rms_avg[1];
      res.pairs      = pairs_cnt[OUT_CNT_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Mismatch reporting
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("tb_top: mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver: pops pending pairs, holds a stalled transfer, random gaps after a
   // transfer. The prediction is made on the edge where the transfer happens.
   // ---------------------------------------------------------------------------------------
   int gap_left = 0;

   always @(posedge clock) begin
      sample_pair_type nxt;
      logic            fire;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire)
            expected_q.push_back(predict_levels(req_left_sample, req_right_sample));
         // a stalled transfer keeps valid and payload as they are
         if (fire || !req_valid) begin
            if (fire && send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct)
               gap_left = $urandom_range(1, 10);
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               nxt = pending_q.pop_front();
               req_valid        <= 1'b1;
               req_left_sample  <= nxt.left;
               req_right_sample <= nxt.right;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor: checks each result transfer against the oldest prediction and
   // drives rsp_stall in random bursts.
   // ---------------------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      level_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_q.pop_front();
               check_field("peak_left",        32'(rsp_peak_left),   32'(want.peak_left));
               check_field("peak_right",       32'(rsp_peak_right),  32'(want.peak_right));
               check_field("clip_count_left",  rsp_clip_count_left,  want.clip_left);
               check_field("clip_count_right", rsp_clip_count_right, want.clip_right);
               check_field("zero_cross_left",  rsp_zero_cross_left,  want.zc_left);
               check_field("zero_cross_right", rsp_zero_cross_right, want.zc_right);
               check_field("silent_count",     rsp_silent_count,     want.silent);
               check_field("rms_left",         32'(rsp_rms_left),    32'(want.rms_left));
               check_field("rms_right",        32'(rsp_rms_right),   32'(want.rms_right));
               check_field("pair_count",       rsp_pair_count,       want.pairs);
               check_field("rms_updated",      32'(rsp_rms_updated), 32'(want.updated));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_stall_pct > 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic void push_pair(int l, int r);
      sample_pair_type sp;
      sp.left  = l[SAMPLE_W-1:0];
      sp.right = r[SAMPLE_W-1:0];
      pending_q.push_back(sp);
   endfunction

   // sample within +-amp; the bounds themselves show up often so magnitude ties occur
   function automatic int pick_sample(int amp);
      int v;
      int top;
      top = (amp > 32767) ? 32767 : amp;
      case ($urandom_range(0, 7))
         0:       v = 0;
         1:       v = $urandom_range(0, 1) ? top : -amp;
         default: v = int'($urandom_range(0, 2 * amp)) - amp;
      endcase
      if (v > 32767)
         v = 32767;
      return v;
   endfunction

   function automatic void push_random_pair(int amp);
      if ($urandom_range(0, 11) == 0)
         push_pair(0, 0);
      else
         push_pair(pick_sample(amp), pick_sample(amp));
   endfunction

   // returns at a falling edge once nothing is queued, in flight or expected
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      // transfer done at this edge; mirror it in the predictor
      case (idx)
         CSR_ENABLE: cfg_enable = data[0];
         CSR_WEIGHT: cfg_weight = data[WEIGHT_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int                    sent;
      int                    n;
      int                    p;
      int                    closes;
      int                    amp;
      bit                    last;
      logic [CSR_DATA_W-1:0] w;

      // predictor starts from the reset state of the unit
      cfg_enable = 1'b1;
      cfg_weight = WEIGHT_RESET;
      for (int ch = 0; ch < 2; ch++) begin
         prev_smp[ch] = '0;
         peak_smp[ch] = '0;
         clip_cnt[ch] = '0;
         zc_cnt[ch]   = '0;
         sum_sq[ch]   = '0;
         rms_avg[ch]  = '0;
      end
      silent_cnt = '0;
      pairs_cnt  = '0;
      blk_pos    = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: silence, ties, sign changes, full scale, alternating bit patterns
      @(negedge clock);
      push_pair(0, 0);
      push_pair(100, -100);
      push_pair(-100, 100);        // equal magnitudes: earlier peak stays
      push_pair(0, 7);             // one channel zero is not silence
      push_pair(-1, -1);
      push_pair(1, 1);
      push_pair(32767, -32768);
      push_pair(-32767, 32767);
      push_pair(-32768, -32767);
      push_pair(-32768, 0);
      push_pair(0, 0);
      push_pair(21845, -21846);
      push_pair(-21846, 21845);
      wait_drained();

      // disabled: pairs leave every statistic alone, silence included
      write_csr(CSR_ENABLE, 17'h1FFFE);
      @(negedge clock);
      push_pair(0, 0);
      push_pair(32767, -32768);
      push_pair(1234, -4321);
      wait_drained();
      write_csr(CSR_ENABLE, 17'h00001);

      // random phases; amplitude grows so the peaks keep moving for a while.
      // The phase that closes a block gets a chosen weight: clamped, mid, exactly one.
      sent   = 0;
      p      = 0;
      closes = 0;
      while (sent < RANDOM_PAIRS) begin
         n = $urandom_range(100, 220);
         if (RANDOM_PAIRS - sent < n + 100)
            n = RANDOM_PAIRS - sent;
         last = (sent + n == RANDOM_PAIRS);
         amp  = (p >= 3) ? 32768 : (64 << (3 * p));

         if (blk_pos + n >= BLOCK_LEN) begin
            case (closes)
               0:       w = 17'h1FFFF;
               1:       w = 17'($urandom_range(1, 65535));
               default: w = WEIGHT_ONE;
            endcase
            closes++;
         end else begin
            case (p % 3)
               0:       w = '0;
               1:       w = WEIGHT_ONE;
               default: w = 17'($urandom_range(0, 131071));
            endcase
         end
         write_csr(CSR_WEIGHT, w);

         if (p % 2 == 1) begin
            write_csr(CSR_ENABLE, {16'($urandom), 1'b0});
            @(negedge clock);
            repeat ($urandom_range(5, 20))
               push_pair(int'($urandom), int'($urandom));
            wait_drained();
            write_csr(CSR_ENABLE, {16'($urandom), 1'b1});
         end

         // some phases run without idling; the final one always does
         if (last || $urandom_range(0, 3) == 0) begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            send_gap_pct  = $urandom_range(10, 60);
            rsp_stall_pct = $urandom_range(10, 60);
         end

         @(negedge clock);
         repeat (n)
            push_random_pair(amp);
         wait_drained();
         sent += n;
         p++;
      end

      // trailing window catches any stray result
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #25ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
